// File: design/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms with a clock and a synchronous reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: design/cwb_pkg.sv
// ============================================================================
// cwb_pkg
// Types and constants shared by the window bounds pipeline.
// ============================================================================
package cwb_pkg;

   localparam int STEP_W   = 5;   // stride, dilation, divisor and step fields
   localparam int POS_W    = 13;  // stored window positions
   localparam int EXT_W    = 13;  // extent register
   localparam int STEP_MAX = 16;  // largest stride or dilation after clamping

   // Control bits that travel with each word down the pipeline.
   typedef struct packed {
      logic valid;
      logic found;   // at least one tap hit so far
      logic tfound;  // tap and position steps already settled
   } cwb_ctl_type;

   typedef enum logic [2:0] {
      CSR_DIRECTION = 3'd0,
      CSR_TAPS      = 3'd1,
      CSR_EXTENT    = 3'd2,
      CSR_PAD       = 3'd3,
      CSR_STRIDE    = 3'd4,
      CSR_DILATION  = 3'd5
   } cwb_csr_type;

endpackage

// File: design/cwb_div_stage.sv
// ============================================================================
// cwb_div_stage
// One restoring division step for two lanes sharing a small divisor.
// ============================================================================
module cwb_div_stage #(
   parameter int DVW = 18
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [cwb_pkg::STEP_W-1:0]  divisor,
   input  cwb_pkg::cwb_ctl_type        up_ctl,
   input  logic [DVW-1:0]              up_numa,
   input  logic [cwb_pkg::STEP_W-1:0]  up_rema,
   input  logic [DVW-1:0]              up_numb,
   input  logic [cwb_pkg::STEP_W-1:0]  up_remb,
   output cwb_pkg::cwb_ctl_type        dn_ctl,
   output logic [DVW-1:0]              dn_numa,
   output logic [cwb_pkg::STEP_W-1:0]  dn_rema,
   output logic [DVW-1:0]              dn_numb,
   output logic [cwb_pkg::STEP_W-1:0]  dn_remb
);
   import cwb_pkg::*;

   cwb_ctl_type         ctl_ff;
   logic [DVW-1:0]      numa_ff, numa_in, numb_ff, numb_in;
   logic [STEP_W-1:0]   rema_ff, rema_in, remb_ff, remb_in;
   logic [STEP_W-1:0]   trial_a, trial_b;

   // The remainder stays below the divisor, so four bits of it plus the next
   // dividend bit always fit the step width.
   always_comb begin
      trial_a = {up_rema[STEP_W-2:0], up_numa[DVW-1]};
      trial_b = {up_remb[STEP_W-2:0], up_numb[DVW-1]};
      if (trial_a >= divisor) begin
         rema_in = trial_a - divisor;
         numa_in = {up_numa[DVW-2:0], 1'b1};
      end else begin
         rema_in = trial_a;
         numa_in = {up_numa[DVW-2:0], 1'b0};
      end
      if (trial_b >= divisor) begin
         remb_in = trial_b - divisor;
         numb_in = {up_numb[DVW-2:0], 1'b1};
      end else begin
         remb_in = trial_b;
         numb_in = {up_numb[DVW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         numa_ff <= numa_in;
         rema_ff <= rema_in;
         numb_ff <= numb_in;
         remb_ff <= remb_in;
      end
   end

   assign dn_ctl  = ctl_ff;
   assign dn_numa = numa_ff;
   assign dn_rema = rema_ff;
   assign dn_numb = numb_ff;
   assign dn_remb = remb_ff;

endmodule

// File: design/cwb_cell.sv
// ============================================================================
// cwb_cell
// One kernel tap of the window chain: tests its tap and steps the position.
// ============================================================================
module cwb_cell #(
   parameter int IDX = 0,
   parameter int TW  = 5,
   parameter int QW  = 19
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [TW-1:0]               taps,
   input  logic [cwb_pkg::EXT_W-1:0]   ext,
   input  logic [cwb_pkg::STEP_W-1:0]  divisor,
   input  cwb_pkg::cwb_ctl_type        up_ctl,
   input  logic signed [QW-1:0]        up_q,
   input  logic [cwb_pkg::STEP_W-1:0]  up_r,
   input  logic [cwb_pkg::STEP_W-1:0]  up_rd,
   input  logic [cwb_pkg::STEP_W-1:0]  up_qd,
   input  logic [cwb_pkg::STEP_W-1:0]  up_dq,
   input  logic [cwb_pkg::STEP_W-1:0]  up_dr,
   input  logic [TW-1:0]               up_f1,
   input  logic [TW-1:0]               up_f2,
   input  logic [cwb_pkg::POS_W-1:0]   up_p1,
   input  logic [cwb_pkg::POS_W-1:0]   up_p2,
   input  logic [cwb_pkg::STEP_W-1:0]  up_ts,
   input  logic [cwb_pkg::STEP_W-1:0]  up_ps,
   output cwb_pkg::cwb_ctl_type        dn_ctl,
   output logic signed [QW-1:0]        dn_q,
   output logic [cwb_pkg::STEP_W-1:0]  dn_r,
   output logic [cwb_pkg::STEP_W-1:0]  dn_rd,
   output logic [cwb_pkg::STEP_W-1:0]  dn_qd,
   output logic [cwb_pkg::STEP_W-1:0]  dn_dq,
   output logic [cwb_pkg::STEP_W-1:0]  dn_dr,
   output logic [TW-1:0]               dn_f1,
   output logic [TW-1:0]               dn_f2,
   output logic [cwb_pkg::POS_W-1:0]   dn_p1,
   output logic [cwb_pkg::POS_W-1:0]   dn_p2,
   output logic [cwb_pkg::STEP_W-1:0]  dn_ts,
   output logic [cwb_pkg::STEP_W-1:0]  dn_ps
);
   import cwb_pkg::*;

   // Each cell tests the dilation multiple for the next tap, so the first
   // STEP_MAX cells cover every possible tap step.
   localparam bit STEP_CELL = (IDX + 1 <= STEP_MAX);

   cwb_ctl_type          ctl_ff, ctl_in;
   logic signed [QW-1:0] q_ff, q_in;
   logic [STEP_W-1:0]    r_ff, r_in, rd_ff, rd_in, qd_ff, qd_in;
   logic [STEP_W-1:0]    dq_ff, dr_ff, ts_ff, ts_in, ps_ff, ps_in;
   logic [STEP_W-1:0]    r_sum, rd_sum;
   logic [TW-1:0]        f1_ff, f1_in, f2_ff, f2_in;
   logic [POS_W-1:0]     p1_ff, p1_in, p2_ff, p2_in;
   logic                 hit, carry, carry_d;

   always_comb begin
      hit = (up_r == '0) && !up_q[QW-1] &&
            (up_q[QW-2:0] < (QW-1)'(ext)) && (TW'(IDX) < taps);

      ctl_in = up_ctl;
      f1_in  = up_f1;
      f2_in  = up_f2;
      p1_in  = up_p1;
      p2_in  = up_p2;
      if (up_ctl.valid && hit) begin
         if (!up_ctl.found) begin
            f1_in = TW'(IDX);
            p1_in = up_q[POS_W-1:0];
         end
         ctl_in.found = 1'b1;
         f2_in = TW'(IDX);
         p2_in = up_q[POS_W-1:0];
      end

      // Advance the quotient and remainder by one dilation for the next tap.
      r_sum = up_r + up_dr;
      carry = (r_sum >= divisor);
      r_in  = carry ? (r_sum - divisor) : r_sum;
      q_in  = up_q + QW'(up_dq) + QW'(carry);

      rd_sum  = up_rd + up_dr;
      carry_d = (rd_sum >= divisor);
      rd_in   = carry_d ? (rd_sum - divisor) : rd_sum;
      qd_in   = up_qd + up_dq + STEP_W'(carry_d);

      // The tap step is the first multiple of the dilation that the divisor
      // divides exactly; the position step is the quotient at that point.
      ts_in = up_ts;
      ps_in = up_ps;
      if (STEP_CELL && !up_ctl.tfound && (rd_in == '0)) begin
         ctl_in.tfound = 1'b1;
         ts_in = STEP_W'(IDX + 1);
         ps_in = qd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff  <= q_in;
         r_ff  <= r_in;
         rd_ff <= rd_in;
         qd_ff <= qd_in;
         dq_ff <= up_dq;
         dr_ff <= up_dr;
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         ts_ff <= ts_in;
         ps_ff <= ps_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_q   = q_ff;
   assign dn_r   = r_ff;
   assign dn_rd  = rd_ff;
   assign dn_qd  = qd_ff;
   assign dn_dq  = dq_ff;
   assign dn_dr  = dr_ff;
   assign dn_f1  = f1_ff;
   assign dn_f2  = f2_ff;
   assign dn_p1  = p1_ff;
   assign dn_p2  = p2_ff;
   assign dn_ts  = ts_ff;
   assign dn_ps  = ps_ff;

endmodule

// File: design/conv_window_bounds_core.sv
// ============================================================================
// conv_window_bounds_core
// Window bounds generator for one dimension of a padded, strided, dilated
// convolution, forward and backward.
// ============================================================================
// Each request word carries one position and yields one response word with the
// tap range, tap step, position range and position step of its window. The
// block takes one word per clock while no response is stalled and is fully
// pipelined: a word passes an entry register, DVW restoring division steps
// (18 with the default parameters), max(MAX_TAPS, 16) tap cells and one output
// register. Forward mode runs the same chain with a divisor of one. When
// a response waits on rsp_tready the whole pipeline holds and req_tready is
// low; otherwise req_tready stays high. Registers are written through the csr
// channel, which is always ready; change them only while no word is in flight.
`include "assert_macros.svh"

module conv_window_bounds_core #(
   parameter int MAX_TAPS   = 16,
   parameter int MAX_EXTENT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] position_index, [15:12] zero
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [3:0] tap_start, [8:4] tap_stop,
                                    // [13:9] tap_step, [25:14] pos_start,
                                    // [38:26] pos_stop, [43:39] pos_step,
                                    // [47:44] zero
);
   import cwb_pkg::*;

   localparam int NCELL  = (MAX_TAPS > STEP_MAX) ? MAX_TAPS : STEP_MAX;
   localparam int TW     = $clog2(NCELL + 1);
   // Bias that keeps every dividend non-negative.
   localparam int OFF_SH = $clog2(STEP_MAX * NCELL);
   localparam int DVW    = (((OFF_SH + STEP_W) > 17) ? (OFF_SH + STEP_W) : 17) + 1;
   localparam int QW     = DVW + 1;
   localparam int BIAS   = 1 << OFF_SH;

   function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] v);
      logic [STEP_W-1:0] res;
      if (v == '0) begin
         res = STEP_W'(1);
      end else if (v > STEP_W'(STEP_MAX)) begin
         res = STEP_W'(STEP_MAX);
      end else begin
         res = v;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- registers
   logic              mode_ff;
   logic [4:0]        taps_ff;
   logic [EXT_W-1:0]  extent_ff;
   logic [7:0]        pad_ff;
   logic [4:0]        stride_ff;
   logic [4:0]        dilation_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         taps_ff     <= 5'd1;
         extent_ff   <= 13'd1;
         pad_ff      <= 8'd0;
         stride_ff   <= 5'd1;
         dilation_ff <= 5'd1;
      end else if (csr_valid && csr_ready) begin
         case (cwb_csr_type'(csr_index))
            CSR_DIRECTION: mode_ff     <= csr_wdata[0];
            CSR_TAPS:      taps_ff     <= csr_wdata[4:0];
            CSR_EXTENT:    extent_ff   <= csr_wdata[12:0];
            CSR_PAD:       pad_ff      <= csr_wdata[7:0];
            CSR_STRIDE:    stride_ff   <= csr_wdata[4:0];
            CSR_DILATION:  dilation_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic [STEP_W-1:0] stride_eff, dil_eff, divisor;
   logic [TW-1:0]     taps_eff, taps_m1;
   logic [EXT_W-1:0]  ext_eff;

   assign stride_eff = clamp_step(stride_ff);
   assign dil_eff    = clamp_step(dilation_ff);
   assign divisor    = mode_ff ? stride_eff : STEP_W'(1);
   assign taps_eff   = (32'(taps_ff) > 32'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(taps_ff);
   assign taps_m1    = (taps_eff == '0) ? '0 : (taps_eff - TW'(1));
   assign ext_eff    = (32'(extent_ff) > 32'(MAX_EXTENT)) ? EXT_W'(MAX_EXTENT) : extent_ff;

   // ---------------------------------------------------------------- entry
   logic                advance;
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [47:0]         rsp_data_ff;
   cwb_ctl_type         entry_ctl_ff;
   logic [DVW-1:0]      entry_num_ff, entry_num_in;
   logic [DVW-1:0]      fwd_num, bwd_num;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Forward: pos*stride - pad. Backward: pos + pad - dilation*(taps-1).
   // Both carry a bias that is a multiple of the divisor.
   always_comb begin
      fwd_num = DVW'(req_tdata[11:0]) * DVW'(stride_eff) - DVW'(pad_ff) + DVW'(BIAS);
      bwd_num = DVW'(req_tdata[11:0]) + DVW'(pad_ff) + (DVW'(divisor) << OFF_SH)
                - DVW'(dil_eff) * DVW'(taps_m1);
      entry_num_in = mode_ff ? bwd_num : fwd_num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ctl_ff <= '0;
      end else if (advance) begin
         entry_ctl_ff <= '{valid: req_tvalid, found: 1'b0, tfound: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_num_ff <= entry_num_in;
      end
   end

   // ---------------------------------------------------------------- divider
   cwb_ctl_type        div_ctl  [0:DVW];
   logic [DVW-1:0]     div_numa [0:DVW];
   logic [STEP_W-1:0]  div_rema [0:DVW];
   logic [DVW-1:0]     div_numb [0:DVW];
   logic [STEP_W-1:0]  div_remb [0:DVW];

   assign div_ctl[0]  = entry_ctl_ff;
   assign div_numa[0] = entry_num_ff;
   assign div_rema[0] = '0;
   assign div_numb[0] = DVW'(dil_eff);
   assign div_remb[0] = '0;

   for (genvar k = 0; k < DVW; k++) begin : g_div
      cwb_div_stage #(.DVW(DVW)) u_div (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .divisor (divisor),
         .up_ctl  (div_ctl[k]),
         .up_numa (div_numa[k]),
         .up_rema (div_rema[k]),
         .up_numb (div_numb[k]),
         .up_remb (div_remb[k]),
         .dn_ctl  (div_ctl[k+1]),
         .dn_numa (div_numa[k+1]),
         .dn_rema (div_rema[k+1]),
         .dn_numb (div_numb[k+1]),
         .dn_remb (div_remb[k+1])
      );
   end

   // ---------------------------------------------------------------- tap chain
   cwb_ctl_type          cell_ctl [0:NCELL];
   logic signed [QW-1:0] cell_q   [0:NCELL];
   logic [STEP_W-1:0]    cell_r   [0:NCELL];
   logic [STEP_W-1:0]    cell_rd  [0:NCELL];
   logic [STEP_W-1:0]    cell_qd  [0:NCELL];
   logic [STEP_W-1:0]    cell_dq  [0:NCELL];
   logic [STEP_W-1:0]    cell_dr  [0:NCELL];
   logic [TW-1:0]        cell_f1  [0:NCELL];
   logic [TW-1:0]        cell_f2  [0:NCELL];
   logic [POS_W-1:0]     cell_p1  [0:NCELL];
   logic [POS_W-1:0]     cell_p2  [0:NCELL];
   logic [STEP_W-1:0]    cell_ts  [0:NCELL];
   logic [STEP_W-1:0]    cell_ps  [0:NCELL];

   // Remove the bias from the quotient of the first tap.
   assign cell_ctl[0] = div_ctl[DVW];
   assign cell_q[0]   = $signed({1'b0, div_numa[DVW]}) - $signed(QW'(BIAS));
   assign cell_r[0]   = div_rema[DVW];
   assign cell_rd[0]  = '0;
   assign cell_qd[0]  = '0;
   assign cell_dq[0]  = div_numb[DVW][STEP_W-1:0];
   assign cell_dr[0]  = div_remb[DVW];
   assign cell_f1[0]  = '0;
   assign cell_f2[0]  = '0;
   assign cell_p1[0]  = '0;
   assign cell_p2[0]  = '0;
   assign cell_ts[0]  = STEP_W'(1);
   assign cell_ps[0]  = STEP_W'(1);

   for (genvar s = 0; s < NCELL; s++) begin : g_cell
      cwb_cell #(.IDX(s), .TW(TW), .QW(QW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .taps    (taps_eff),
         .ext     (ext_eff),
         .divisor (divisor),
         .up_ctl  (cell_ctl[s]),
         .up_q    (cell_q[s]),
         .up_r    (cell_r[s]),
         .up_rd   (cell_rd[s]),
         .up_qd   (cell_qd[s]),
         .up_dq   (cell_dq[s]),
         .up_dr   (cell_dr[s]),
         .up_f1   (cell_f1[s]),
         .up_f2   (cell_f2[s]),
         .up_p1   (cell_p1[s]),
         .up_p2   (cell_p2[s]),
         .up_ts   (cell_ts[s]),
         .up_ps   (cell_ps[s]),
         .dn_ctl  (cell_ctl[s+1]),
         .dn_q    (cell_q[s+1]),
         .dn_r    (cell_r[s+1]),
         .dn_rd   (cell_rd[s+1]),
         .dn_qd   (cell_qd[s+1]),
         .dn_dq   (cell_dq[s+1]),
         .dn_dr   (cell_dr[s+1]),
         .dn_f1   (cell_f1[s+1]),
         .dn_f2   (cell_f2[s+1]),
         .dn_p1   (cell_p1[s+1]),
         .dn_p2   (cell_p2[s+1]),
         .dn_ts   (cell_ts[s+1]),
         .dn_ps   (cell_ps[s+1])
      );
   end

   // ---------------------------------------------------------------- output
   logic [47:0] rsp_data_in;
   logic [TW-1:0]    f2_next;
   logic [POS_W-1:0] p2_next;

   always_comb begin
      f2_next = cell_f2[NCELL] + TW'(1);
      p2_next = cell_p2[NCELL] + POS_W'(1);
      if (cell_ctl[NCELL].found) begin
         rsp_data_in = {4'd0, cell_ps[NCELL], p2_next, cell_p1[NCELL][11:0],
                        cell_ts[NCELL], f2_next[4:0], cell_f1[NCELL][3:0]};
      end else begin
         // No tap touches valid data: empty ranges with unit steps.
         rsp_data_in = {4'd0, 5'd1, 13'd0, 12'd0, 5'd1, 5'd0, 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_found_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cell_ctl[NCELL].valid;
         rsp_found_ff <= cell_ctl[NCELL].found;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_IMPLY(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready, entry_ctl_ff.valid)
   `ASSERT_IMPLY(a_step_settled, clock, reset, cell_ctl[NCELL].valid && cell_ctl[NCELL].found, cell_ctl[NCELL].tfound)
   `ASSERT_IMPLY(a_forward_unit_step, clock, reset, rsp_tvalid && rsp_found_ff && !mode_ff, rsp_tdata[13:9] == 5'd1)

endmodule

// File: sim/cwb_window_checker.sv
// ============================================================================
// cwb_window_checker
// Watches the csr, request and response channels of the window bounds core.
// It keeps its own copy of the registers and predicts every response word.
// Each response word is then compared field by field with the oldest
// prediction.
// ============================================================================
`timescale 1ns / 1ps

module cwb_window_checker #(
   parameter int MAX_TAPS   = 16,
   parameter int MAX_EXTENT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] position_index, [15:12] zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [3:0] tap_start, [8:4] tap_stop,
                                    // [13:9] tap_step, [25:14] pos_start,
                                    // [38:26] pos_stop, [43:39] pos_step,
                                    // [47:44] zero
   output int          error_count,
   output int          pending_words,
   output int          windows_checked,
   output int          windows_hit
);
   import cwb_pkg::*;

   localparam int PRINT_LIMIT = 40;

   // Packed so that it lines up with rsp_tdata[43:0].
   typedef struct packed {
      logic [4:0]  pos_step;
      logic [12:0] pos_stop;
      logic [11:0] pos_start;
      logic [4:0]  tap_step;
      logic [4:0]  tap_stop;
      logic [3:0]  tap_start;
   } window_type;

   logic        backward_mode;
   logic [4:0]  cfg_taps;
   logic [12:0] cfg_extent;
   logic [7:0]  cfg_pad;
   logic [4:0]  cfg_stride;
   logic [4:0]  cfg_dilation;

   window_type expected_windows[$];

   function automatic int clamp_step(input logic [4:0] value);
      if (value == 0) return 1;
      if (value > STEP_MAX) return STEP_MAX;
      return int'(value);
   endfunction

   function automatic window_type window_bounds(input logic [11:0] position);
      int taps, ext, str, dil, base, tap, at, quot;
      int first_tap, last_tap, first_pos, last_pos, tstep, pstep, a, b, r;
      bit hit;
      window_type w;
      taps = (cfg_taps > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
      ext = (cfg_extent > MAX_EXTENT) ? MAX_EXTENT : int'(cfg_extent);
      str = clamp_step(cfg_stride);
      dil = clamp_step(cfg_dilation);
      hit = 1'b0;
      first_tap = 0;
      last_tap = 0;
      first_pos = 0;
      last_pos = 0;
      if (!backward_mode) begin
         base = int'(position) * str - int'(cfg_pad);
         for (tap = 0; tap < taps; tap++) begin
            at = base + tap * dil;
            if (at >= 0 && at < ext) begin
               if (!hit) begin
                  first_tap = tap;
                  first_pos = at;
                  hit = 1'b1;
               end
               last_tap = tap;
               last_pos = at;
            end
         end
         tstep = 1;
         pstep = dil;
      end else begin
         // Tap s lands on an output only when the offset divides by the stride.
         base = int'(position) - (dil * (taps - 1) - int'(cfg_pad));
         for (tap = 0; tap < taps; tap++) begin
            at = base + tap * dil;
            quot = at / str;
            if (at % str == 0 && quot >= 0 && quot < ext) begin
               if (!hit) begin
                  first_tap = tap;
                  first_pos = quot;
                  hit = 1'b1;
               end
               last_tap = tap;
               last_pos = quot;
            end
         end
         a = str;
         b = dil;
         while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
         end
         tstep = str / a;
         pstep = (tstep * dil) / str;
      end
      w = '0;
      w.tap_step = 5'd1;
      w.pos_step = 5'd1;
      if (hit) begin
         w.tap_start = first_tap[3:0];
         w.tap_stop  = 5'(last_tap + 1);
         w.tap_step  = tstep[4:0];
         w.pos_start = first_pos[11:0];
         w.pos_stop  = 13'(last_pos + 1);
         w.pos_step  = pstep[4:0];
      end
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got)
         report_mismatch($sformatf("word %0d %s: expected %0d, got %0d",
                                   windows_checked, name, want, got));
   endtask

   always @(posedge clock) begin
      window_type want, got;
      if (reset) begin
         backward_mode = 1'b0;
         cfg_taps = 5'd1;
         cfg_extent = 13'd1;
         cfg_pad = 8'd0;
         cfg_stride = 5'd1;
         cfg_dilation = 5'd1;
         expected_windows.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIRECTION: backward_mode = csr_wdata[0];
               CSR_TAPS:      cfg_taps = csr_wdata[4:0];
               CSR_EXTENT:    cfg_extent = csr_wdata;
               CSR_PAD:       cfg_pad = csr_wdata[7:0];
               CSR_STRIDE:    cfg_stride = csr_wdata[4:0];
               CSR_DILATION:  cfg_dilation = csr_wdata[4:0];
               default: ;
            endcase
         end
         // Responses are matched before this edge's request is queued.
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[43:0];
            if (expected_windows.size() == 0) begin
               report_mismatch("response word arrived with no request outstanding");
            end else begin
               want = expected_windows.pop_front();
               check_field("tap_start", want.tap_start, got.tap_start);
               check_field("tap_stop", want.tap_stop, got.tap_stop);
               check_field("tap_step", want.tap_step, got.tap_step);
               check_field("pos_start", want.pos_start, got.pos_start);
               check_field("pos_stop", want.pos_stop, got.pos_stop);
               check_field("pos_step", want.pos_step, got.pos_step);
               check_field("padding", 0, rsp_tdata[47:44]);
               windows_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            want = window_bounds(req_tdata[11:0]);
            if (want.tap_stop != 0) windows_hit++;
            expected_windows.push_back(want);
         end
      end
      pending_words <= expected_windows.size();
   end

endmodule

// File: sim/tb_conv_window_bounds_core.sv
// ============================================================================
// tb_conv_window_bounds_core
// Drives position words and register settings into the window bounds core.
// A short directed pass covers the field extremes, both directions, empty
// windows and saturated registers. Random settings and positions follow,
// with random gaps on both streams and one long response stall.
// ============================================================================
`timescale 1ns / 1ps

module tb_conv_window_bounds_core;
   import cwb_pkg::*;

   localparam int MAX_TAPS        = 16;
   localparam int MAX_EXTENT      = 4096;
   localparam int RESET_CYCLES    = 9;
   localparam int RANDOM_WORDS    = 1800;
   localparam int MAX_GAP         = 18;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int PRESSURE_WORDS  = 150;
   localparam int PRESSURE_PHASE  = 3;
   localparam int SETTLE_CYCLES   = 64;
   localparam int STALL_LIMIT     = 4000;

   localparam logic [12:0] DIR_FORWARD  = 13'd0;
   localparam logic [12:0] DIR_BACKWARD = 13'd1;
   localparam logic [2:0]  CSR_SPARE_LO = 3'd6;
   localparam logic [2:0]  CSR_SPARE_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [12:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [11:0] position_index, [15:12] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [3:0] tap_start, [8:4] tap_stop, [13:9] tap_step,
                             // [25:14] pos_start, [38:26] pos_stop,
                             // [43:39] pos_step, [47:44] zero

   int error_count;
   int pending_words;
   int windows_checked;
   int windows_hit;

   bit req_gaps_on;
   bit rsp_gaps_on;
   bit hold_off_request;
   int settings_applied;

   // Register values as the block holds them, used to aim the positions.
   logic        cur_backward;
   logic [4:0]  cur_taps;
   logic [12:0] cur_extent;
   logic [7:0]  cur_pad;
   logic [4:0]  cur_stride;
   logic [4:0]  cur_dilation;

   conv_window_bounds_core #(
      .MAX_TAPS   (MAX_TAPS),
      .MAX_EXTENT (MAX_EXTENT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cwb_window_checker #(
      .MAX_TAPS   (MAX_TAPS),
      .MAX_EXTENT (MAX_EXTENT)
   ) window_check (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .error_count     (error_count),
      .pending_words   (pending_words),
      .windows_checked (windows_checked),
      .windows_hit     (windows_hit)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_position(input logic [11:0] position);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, position};
      do @(posedge clock); while (!req_tready);
   endtask

   // Returns at an edge where every queued window has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic write_register(input logic [2:0] index, input logic [12:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input logic [12:0] direction, input logic [12:0] taps,
                                input logic [12:0] extent, input logic [12:0] pad,
                                input logic [12:0] stride, input logic [12:0] dilation);
      write_register(CSR_DIRECTION, direction);
      write_register(CSR_TAPS, taps);
      write_register(CSR_EXTENT, extent);
      write_register(CSR_PAD, pad);
      // Writes to unused indexes must leave every register alone.
      if ($urandom_range(0, 3) == 0)
         write_register($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                        13'($urandom_range(0, 8191)));
      write_register(CSR_STRIDE, stride);
      write_register(CSR_DILATION, dilation);
      csr_valid <= 1'b0;
      cur_backward = direction[0];
      cur_taps = taps[4:0];
      cur_extent = extent;
      cur_pad = pad[7:0];
      cur_stride = stride[4:0];
      cur_dilation = dilation[4:0];
      settings_applied++;
   endtask

   function automatic logic [12:0] draw_step();
      case ($urandom_range(0, 9))
         0:       return 13'($urandom_range(0, 31));
         1:       return 13'($urandom_range(0, 8191));
         2:       return 13'd1;
         3:       return 13'd16;
         default: return 13'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic logic [12:0] draw_extent();
      case ($urandom_range(0, 9))
         0:       return 13'd1;
         1:       return 13'd4096;
         2:       return 13'($urandom_range(0, 8191));
         3, 4, 5: return 13'($urandom_range(1, 32));
         default: return 13'($urandom_range(1, 4096));
      endcase
   endfunction

   function automatic logic [12:0] draw_pad();
      case ($urandom_range(0, 9))
         0:       return 13'd0;
         1:       return 13'd255;
         2:       return 13'($urandom_range(0, 8191));
         3, 4, 5: return 13'($urandom_range(0, 8));
         default: return 13'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int step_in_use(input logic [4:0] value);
      if (value == 0) return 1;
      return (value > STEP_MAX) ? STEP_MAX : int'(value);
   endfunction

   // Most positions fall in the range where the window can reach the extent.
   function automatic logic [11:0] draw_position();
      int taps, ext, str, dil, reach;
      taps = (cur_taps > MAX_TAPS) ? MAX_TAPS : int'(cur_taps);
      ext = (cur_extent > MAX_EXTENT) ? MAX_EXTENT : int'(cur_extent);
      str = step_in_use(cur_stride);
      dil = step_in_use(cur_dilation);
      if (cur_backward) reach = ext * str + dil * taps;
      else reach = (ext + int'(cur_pad)) / str + 1;
      if (reach > 4095) reach = 4095;
      if ($urandom_range(0, 4) == 0) return 12'($urandom_range(0, 4095));
      return 12'($urandom_range(0, reach));
   endfunction

   // Response side: a random wait before every word while rsp_gaps_on is set, or one long hold-off.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_request) begin
            gap = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end else begin
            gap = rsp_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int random_sent, phase_words, phase_count;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_DIRECTION;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      cur_backward = 1'b0;
      cur_taps = 5'd1;
      cur_extent = 13'd1;
      cur_pad = 8'd0;
      cur_stride = 5'd1;
      cur_dilation = 5'd1;
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Registers as they come out of reset: one tap over a one-element extent.
      send_position(12'd0);
      send_position(12'd1);
      send_position(12'd4095);
      drain_responses();

      // Largest taps, extent, pad, stride and dilation in both directions.
      apply_setting(DIR_FORWARD, 13'd16, 13'd4096, 13'd255, 13'd16, 13'd16);
      send_position(12'd0);
      send_position(12'd16);
      send_position(12'd4095);
      drain_responses();
      apply_setting(DIR_BACKWARD, 13'd16, 13'd4096, 13'd255, 13'd16, 13'd16);
      send_position(12'd0);
      send_position(12'd300);
      send_position(12'd4095);
      drain_responses();

      // Stride and dilation sharing a factor give a tap step above one.
      apply_setting(DIR_BACKWARD, 13'd7, 13'd100, 13'd3, 13'd6, 13'd4);
      send_position(12'd50);
      send_position(12'd7);
      drain_responses();

      // Zero taps, then zero extent: both leave the window empty.
      apply_setting(DIR_FORWARD, 13'd0, 13'd50, 13'd2, 13'd1, 13'd1);
      send_position(12'd10);
      drain_responses();
      apply_setting(DIR_BACKWARD, 13'd5, 13'd0, 13'd0, 13'd1, 13'd1);
      send_position(12'd3);
      drain_responses();

      // Zero steps count as one, and oversized values saturate.
      apply_setting(DIR_BACKWARD, 13'd31, 13'd8191, 13'd0, 13'd0, 13'd0);
      send_position(12'd4095);
      send_position(12'd2);
      drain_responses();
      apply_setting(DIR_FORWARD, 13'd17, 13'd5000, 13'd7, 13'd31, 13'd20);
      send_position(12'd200);
      send_position(12'd4095);
      drain_responses();

      write_register(CSR_SPARE_LO, 13'h1FFF);
      write_register(CSR_SPARE_HI, 13'h0000);
      csr_valid <= 1'b0;
      send_position(12'd201);
      drain_responses();

      random_sent = 0;
      phase_count = 0;
      while (random_sent < RANDOM_WORDS) begin
         apply_setting(($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                                   : 13'($urandom_range(0, 1)),
                       draw_step(), draw_extent(), draw_pad(), draw_step(), draw_step());
         req_gaps_on = ($urandom_range(0, 2) != 0);
         rsp_gaps_on = ($urandom_range(0, 2) != 0);
         phase_words = $urandom_range(30, 90);
         // Back-to-back requests against a stalled output fill the pipeline.
         if (phase_count == PRESSURE_PHASE) begin
            req_gaps_on = 1'b0;
            hold_off_request = 1'b1;
            phase_words = PRESSURE_WORDS;
         end
         repeat (phase_words) send_position(draw_position());
         drain_responses();
         random_sent += phase_words;
         phase_count++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d window words, %0d with valid taps, over %0d register settings",
               windows_checked, windows_hit, settings_applied);
      $display("in both directions, including empty and saturated configurations.");
      if (error_count == 0 && pending_words == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/cwb_pkg.sv
design/cwb_div_stage.sv
design/cwb_cell.sv
design/conv_window_bounds_core.sv
sim/cwb_window_checker.sv
sim/tb_conv_window_bounds_core.sv
